### rtl/core/mfsg_pkg.sv
// Shared constants, payload structs and saturating fixed-point helpers
// for the matrix-factorisation gradient engine. No dependencies.
package mfsg_pkg;

  localparam int unsigned USER_SLOTS  = 256;
  localparam int unsigned ITEM_SLOTS  = 1024;
  localparam int unsigned MAX_FACTORS = 16;
  localparam int unsigned FRAC_BITS   = 24;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SLOT_W     = $clog2(USER_SLOTS);
  localparam int unsigned KEY_W      = $clog2(ITEM_SLOTS);
  localparam int unsigned FAC_W      = $clog2(MAX_FACTORS);
  localparam int unsigned FC_W       = $clog2(MAX_FACTORS + 1);
  localparam int unsigned UW_DEPTH   = USER_SLOTS * MAX_FACTORS;
  localparam int unsigned IW_DEPTH   = ITEM_SLOTS * MAX_FACTORS;
  localparam int unsigned CFG_ADDR_W = 4;

  // Input modes
  localparam logic [1:0] MODE_WR_USER = 2'd0;
  localparam logic [1:0] MODE_WR_ITEM = 2'd1;
  localparam logic [1:0] MODE_RATING  = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE       = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GLOBAL_BIAS     = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FACTOR_COUNT    = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_USER_FACTOR_REG = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ITEM_FACTOR_REG = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_USER_BIAS_REG   = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ITEM_BIAS_REG   = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_USER_BASE       = 4'd7;

  // 0.01 in Q8.24
  localparam logic signed [DATA_W-1:0] RST_0P01 = 32'sd167772;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]               mode;
    logic [7:0]               user_slot;
    logic [9:0]               item_key;
    logic [4:0]               word_index;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0]        global_user;
    logic [9:0]               item_out;
    logic [3:0]               factor_out;
    logic signed [DATA_W-1:0] prediction;
    logic signed [DATA_W-1:0] user_delta;
    logic signed [DATA_W-1:0] item_delta;
    logic signed [DATA_W-1:0] user_bias_sum;
    logic signed [DATA_W-1:0] item_bias_sum;
    logic                     saturated;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]     wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] step_size;
    logic signed [DATA_W-1:0] global_bias;
    logic [4:0]               factor_count;
    logic signed [DATA_W-1:0] user_factor_reg;
    logic signed [DATA_W-1:0] item_factor_reg;
    logic signed [DATA_W-1:0] user_bias_reg;
    logic signed [DATA_W-1:0] item_bias_reg;
    logic [DATA_W-1:0]        user_base;
  } cfg_t;

  // Saturated result with its overflow flag
  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } sres_t;

  // Add or subtract with clamping to the signed 32-bit range
  function automatic sres_t sat_addsub(logic signed [DATA_W-1:0] a,
                                       logic signed [DATA_W-1:0] b,
                                       logic sub);
    logic [DATA_W:0] s;
    sres_t r;
    if (sub) begin
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
    r.sat = s[DATA_W] ^ s[DATA_W-1];
    if (r.sat) begin
      r.val = s[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = s[DATA_W-1:0];
    end
    return r;
  endfunction

  // Floor shift of a full product back to Q8.24, clamped to 32 bits
  function automatic sres_t sat_shift(logic signed [2*DATA_W-1:0] p);
    logic signed [2*DATA_W-1:0] sh;
    sres_t r;
    sh    = p >>> FRAC_BITS;
    r.sat = !((&sh[2*DATA_W-1:DATA_W-1]) || !(|sh[2*DATA_W-1:DATA_W-1]));
    if (r.sat) begin
      r.val = sh[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = sh[DATA_W-1:0];
    end
    return r;
  endfunction

  // Zero counts as one factor, anything above the table width as the maximum
  function automatic logic [FC_W-1:0] clamp_fc(logic [4:0] f);
    logic [FC_W-1:0] r;
    if (f == 5'd0) begin
      r = FC_W'(1);
    end else if (f > 5'(MAX_FACTORS)) begin
      r = FC_W'(MAX_FACTORS);
    end else begin
      r = FC_W'(f);
    end
    return r;
  endfunction

endpackage

### rtl/core/mfsg_if.sv
// Valid/ready channel interfaces for input items, results and
// configuration writes. Depends on mfsg_pkg.
interface mfsg_in_if;
  logic          valid;
  logic          ready;
  mfsg_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfsg_out_if;
  logic           valid;
  logic           ready;
  mfsg_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfsg_cfg_if;
  logic              valid;
  logic              ready;
  mfsg_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/mf_sgd_gradient_engine.sv
// Matrix-factorisation SGD gradient engine. One item is worked at a time;
// a rating fills the delta buffer for all fc factors in use before the first
// result appears, then gives one result per factor, each after a buffer read
// step and held while the output stalls.
// After reset and after each clear the bias accumulators are swept to zero,
// during which no item is taken.
module mf_sgd_gradient_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfsg_cfg_if.sink   cfg_i,
  mfsg_in_if.sink    in_i,
  mfsg_out_if.source out_o
);
  import mfsg_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_CLR     = 5'd1;
  localparam logic [4:0] ST_BIAS    = 5'd2;
  localparam logic [4:0] ST_PRED0   = 5'd3;
  localparam logic [4:0] ST_PRED1   = 5'd4;
  localparam logic [4:0] ST_DOT_RD  = 5'd5;
  localparam logic [4:0] ST_DOT_MUL = 5'd6;
  localparam logic [4:0] ST_DOT_ADD = 5'd7;
  localparam logic [4:0] ST_ERR     = 5'd8;
  localparam logic [4:0] ST_UB0     = 5'd9;
  localparam logic [4:0] ST_UB1     = 5'd10;
  localparam logic [4:0] ST_UB2     = 5'd11;
  localparam logic [4:0] ST_UB3     = 5'd12;
  localparam logic [4:0] ST_IB0     = 5'd13;
  localparam logic [4:0] ST_IB1     = 5'd14;
  localparam logic [4:0] ST_IB2     = 5'd15;
  localparam logic [4:0] ST_IB3     = 5'd16;
  localparam logic [4:0] ST_WACC    = 5'd17;
  localparam logic [4:0] ST_D_RD    = 5'd18;
  localparam logic [4:0] ST_D0      = 5'd19;
  localparam logic [4:0] ST_D1      = 5'd20;
  localparam logic [4:0] ST_D2      = 5'd21;
  localparam logic [4:0] ST_D3      = 5'd22;
  localparam logic [4:0] ST_D4      = 5'd23;
  localparam logic [4:0] ST_D5      = 5'd24;
  localparam logic [4:0] ST_D6      = 5'd25;
  localparam logic [4:0] ST_D7      = 5'd26;
  localparam logic [4:0] ST_D8      = 5'd27;
  localparam logic [4:0] ST_EMIT_RD = 5'd28;
  localparam logic [4:0] ST_EMIT    = 5'd29;

  cfg_t cfg;

  logic [4:0]       state_q, state_d;
  logic [KEY_W-1:0] clr_q, clr_d;
  logic [FC_W-1:0]  k_q, k_d;

  logic [SLOT_W-1:0]        slot_q;
  logic [KEY_W-1:0]         key_q;
  logic signed [DATA_W-1:0] val_q;
  logic [DATA_W-1:0]        gu_q;
  logic [FC_W-1:0]          fc_q;
  logic signed [DATA_W-1:0] pred_q, err_q, ub_q, ib_q, uacc_q, iacc_q;
  logic signed [DATA_W-1:0] t1_q, ud_q, uw_q, iw_q;
  logic                     sat_q;

  logic in_acc, out_acc, is_idle, is_last;

  logic signed [DATA_W-1:0] mul_a, mul_b, add_a, add_b;
  logic                     mul_en, add_sub, add_use, fm_use;
  sres_t                    fm, add_res;

  logic signed [DATA_W-1:0] ub_rd, ib_rd, uw_rd, iw_rd, ua_rd, ia_rd;
  logic [2*DATA_W-1:0]      buf_rd;

  logic                     ub_we, ib_we, uw_we, iw_we, acc_we;
  logic [SLOT_W-1:0]        ub_addr, ua_addr;
  logic [KEY_W-1:0]         ib_addr, ia_addr;
  logic [SLOT_W+FAC_W-1:0]  uw_addr;
  logic [KEY_W+FAC_W-1:0]   iw_addr;
  logic [FAC_W-1:0]         wr_fac;
  logic                     word_ok;

  mfsg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mfsg_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (fm)
  );

  // Handshake
  assign is_idle     = (state_q == ST_IDLE);
  assign in_i.ready  = is_idle;
  assign in_acc      = in_i.valid && is_idle;
  assign out_o.valid = (state_q == ST_EMIT);
  assign out_acc     = out_o.valid && out_o.ready;
  assign is_last     = (k_q == fc_q - FC_W'(1));

  // Table write decode for load transfers
  assign word_ok = (in_i.data.word_index <= 5'(MAX_FACTORS));
  assign wr_fac  = FAC_W'(in_i.data.word_index - 5'd1);
  assign ub_we   = in_acc && (in_i.data.mode == MODE_WR_USER) &&
                   (in_i.data.word_index == 5'd0);
  assign uw_we   = in_acc && (in_i.data.mode == MODE_WR_USER) && word_ok &&
                   (in_i.data.word_index != 5'd0);
  assign ib_we   = in_acc && (in_i.data.mode == MODE_WR_ITEM) &&
                   (in_i.data.word_index == 5'd0);
  assign iw_we   = in_acc && (in_i.data.mode == MODE_WR_ITEM) && word_ok &&
                   (in_i.data.word_index != 5'd0);
  assign acc_we  = (state_q == ST_CLR) || (state_q == ST_WACC);

  // Addresses: inputs while idle, latched rating otherwise, sweep count on clear
  assign ub_addr = is_idle ? in_i.data.user_slot : slot_q;
  assign ib_addr = is_idle ? in_i.data.item_key : key_q;
  assign uw_addr = is_idle ? {in_i.data.user_slot, wr_fac} : {slot_q, k_q[FAC_W-1:0]};
  assign iw_addr = is_idle ? {in_i.data.item_key, wr_fac} : {key_q, k_q[FAC_W-1:0]};
  assign ua_addr = (state_q == ST_CLR) ? clr_q[SLOT_W-1:0] : slot_q;
  assign ia_addr = (state_q == ST_CLR) ? clr_q : key_q;

  mfsg_ram #(.WIDTH(DATA_W), .DEPTH(USER_SLOTS)) u_user_bias (
    .clk_i (clk_i), .we_i (ub_we), .addr_i (ub_addr),
    .wdata_i (in_i.data.value), .rdata_o (ub_rd)
  );

  mfsg_ram #(.WIDTH(DATA_W), .DEPTH(ITEM_SLOTS)) u_item_bias (
    .clk_i (clk_i), .we_i (ib_we), .addr_i (ib_addr),
    .wdata_i (in_i.data.value), .rdata_o (ib_rd)
  );

  mfsg_ram #(.WIDTH(DATA_W), .DEPTH(UW_DEPTH)) u_user_weight (
    .clk_i (clk_i), .we_i (uw_we), .addr_i (uw_addr),
    .wdata_i (in_i.data.value), .rdata_o (uw_rd)
  );

  mfsg_ram #(.WIDTH(DATA_W), .DEPTH(IW_DEPTH)) u_item_weight (
    .clk_i (clk_i), .we_i (iw_we), .addr_i (iw_addr),
    .wdata_i (in_i.data.value), .rdata_o (iw_rd)
  );

  mfsg_ram #(.WIDTH(DATA_W), .DEPTH(USER_SLOTS)) u_user_acc (
    .clk_i (clk_i), .we_i (acc_we), .addr_i (ua_addr),
    .wdata_i ((state_q == ST_CLR) ? '0 : uacc_q), .rdata_o (ua_rd)
  );

  mfsg_ram #(.WIDTH(DATA_W), .DEPTH(ITEM_SLOTS)) u_item_acc (
    .clk_i (clk_i), .we_i (acc_we), .addr_i (ia_addr),
    .wdata_i ((state_q == ST_CLR) ? '0 : iacc_q), .rdata_o (ia_rd)
  );

  // Per-factor delta pairs, filled before the first result goes out
  mfsg_ram #(.WIDTH(2*DATA_W), .DEPTH(MAX_FACTORS)) u_delta_buf (
    .clk_i (clk_i), .we_i (state_q == ST_D8), .addr_i (k_q[FAC_W-1:0]),
    .wdata_i ({ud_q, fm.val}), .rdata_o (buf_rd)
  );

  // Multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q) inside
      ST_DOT_MUL: begin mul_a = uw_rd; mul_b = iw_rd; end
      ST_UB0:     begin mul_a = cfg.user_bias_reg; mul_b = ub_q; end
      ST_IB0:     begin mul_a = cfg.item_bias_reg; mul_b = ib_q; end
      ST_UB2, ST_IB2, ST_D3, ST_D7: begin
        mul_a = cfg.step_size;
        mul_b = t1_q;
      end
      ST_D0:      begin mul_a = err_q; mul_b = iw_rd; end
      ST_D1:      begin mul_a = cfg.user_factor_reg; mul_b = uw_q; end
      ST_D4:      begin mul_a = err_q; mul_b = uw_q; end
      ST_D5:      begin mul_a = cfg.item_factor_reg; mul_b = iw_q; end
      default:    mul_en = 1'b0;
    endcase
  end

  // Adder operand select
  always_comb begin
    add_a   = pred_q;
    add_b   = fm.val;
    add_sub = 1'b0;
    add_use = 1'b1;
    unique case (state_q) inside
      ST_PRED0:   begin add_a = cfg.global_bias; add_b = ub_rd; end
      ST_PRED1:   add_b = ib_q;
      ST_DOT_ADD: ;
      ST_ERR:     begin add_a = val_q; add_b = pred_q; add_sub = 1'b1; end
      ST_UB1, ST_IB1: begin add_a = err_q; add_sub = 1'b1; end
      ST_UB3:     add_a = uacc_q;
      ST_IB3:     add_a = iacc_q;
      ST_D2, ST_D6: begin add_a = t1_q; add_sub = 1'b1; end
      default:    add_use = 1'b0;
    endcase
  end

  assign add_res = sat_addsub(add_a, add_b, add_sub);

  // Multiplier results consumed in these steps
  always_comb begin
    unique case (state_q) inside
      ST_DOT_ADD, ST_UB1, ST_UB3, ST_IB1, ST_IB3,
      ST_D1, ST_D2, ST_D4, ST_D5, ST_D6, ST_D8: fm_use = 1'b1;
      default: fm_use = 1'b0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (in_acc) begin
          unique case (in_i.data.mode)
            MODE_RATING: state_d = ST_BIAS;
            MODE_CLEAR: begin
              state_d = ST_CLR;
              clr_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        clr_d = clr_q + KEY_W'(1);
        if (clr_q == KEY_W'(ITEM_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_BIAS:    state_d = ST_PRED0;
      ST_PRED0:   state_d = ST_PRED1;
      ST_PRED1:   state_d = ST_DOT_RD;
      ST_DOT_RD:  state_d = ST_DOT_MUL;
      ST_DOT_MUL: state_d = ST_DOT_ADD;
      ST_DOT_ADD: begin
        if (k_q + FC_W'(1) == fc_q) begin
          k_d     = '0;
          state_d = ST_ERR;
        end else begin
          k_d     = k_q + FC_W'(1);
          state_d = ST_DOT_RD;
        end
      end
      ST_ERR:  state_d = ST_UB0;
      ST_UB0:  state_d = ST_UB1;
      ST_UB1:  state_d = ST_UB2;
      ST_UB2:  state_d = ST_UB3;
      ST_UB3:  state_d = ST_IB0;
      ST_IB0:  state_d = ST_IB1;
      ST_IB1:  state_d = ST_IB2;
      ST_IB2:  state_d = ST_IB3;
      ST_IB3:  state_d = ST_WACC;
      ST_WACC: state_d = ST_D_RD;
      ST_D_RD: state_d = ST_D0;
      ST_D0:   state_d = ST_D1;
      ST_D1:   state_d = ST_D2;
      ST_D2:   state_d = ST_D3;
      ST_D3:   state_d = ST_D4;
      ST_D4:   state_d = ST_D5;
      ST_D5:   state_d = ST_D6;
      ST_D6:   state_d = ST_D7;
      ST_D7:   state_d = ST_D8;
      ST_D8: begin
        if (k_q + FC_W'(1) == fc_q) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          k_d     = k_q + FC_W'(1);
          state_d = ST_D_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) begin
          if (is_last) begin
            k_d     = '0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + FC_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers; reset starts the accumulator sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q <= in_i.data.user_slot;
      key_q  <= in_i.data.item_key;
      val_q  <= in_i.data.value;
      gu_q   <= cfg.user_base + DATA_W'(in_i.data.user_slot);
      fc_q   <= clamp_fc(cfg.factor_count);
      sat_q  <= 1'b0;
    end else begin
      sat_q  <= sat_q | (fm_use & fm.sat) | (add_use & add_res.sat);
    end
    case (state_q) inside
      ST_PRED0: begin
        pred_q <= add_res.val;
        ub_q   <= ub_rd;
        ib_q   <= ib_rd;
        uacc_q <= ua_rd;
        iacc_q <= ia_rd;
      end
      ST_PRED1, ST_DOT_ADD:         pred_q <= add_res.val;
      ST_ERR:                       err_q  <= add_res.val;
      ST_UB1, ST_IB1, ST_D2, ST_D6: t1_q   <= add_res.val;
      ST_UB3:                       uacc_q <= add_res.val;
      ST_IB3:                       iacc_q <= add_res.val;
      ST_D0: begin
        uw_q <= uw_rd;
        iw_q <= iw_rd;
      end
      ST_D1, ST_D5:                 t1_q   <= fm.val;
      ST_D4:                        ud_q   <= fm.val;
      default: ;
    endcase
  end

  // Result payload, held while the read address stays on the current factor
  assign out_o.data.global_user   = gu_q;
  assign out_o.data.item_out      = key_q;
  assign out_o.data.factor_out    = k_q[FAC_W-1:0];
  assign out_o.data.prediction    = pred_q;
  assign out_o.data.user_delta    = buf_rd[2*DATA_W-1:DATA_W];
  assign out_o.data.item_delta    = buf_rd[DATA_W-1:0];
  assign out_o.data.user_bias_sum = uacc_q;
  assign out_o.data.item_bias_sum = iacc_q;
  assign out_o.data.saturated     = sat_q;
  assign out_o.data.last          = is_last;

  // Factor index never runs past the clamped count while results go out
  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (k_q < fc_q))
    else $error("result factor index beyond factor count");

  // A clear transfer starts the accumulator sweep
  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.data.mode == MODE_CLEAR)) |=> (state_q == ST_CLR) && (clr_q == '0))
    else $error("clear did not start sweep");

  // The final result of a rating returns the engine to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.data.last) |=> (state_q == ST_IDLE))
    else $error("engine busy after last result");

  // Clamped factor count stays in range while a rating is worked
  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ST_IDLE) && (state_q != ST_CLR)) |->
      ((fc_q != '0) && (fc_q <= FC_W'(MAX_FACTORS))))
    else $error("factor count out of range");

endmodule

### rtl/core/mfsg_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Read-before-write. No dependencies.
module mfsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mfsg_cfg.sv
// Configuration register file, written over its own valid/ready channel.
// Depends on mfsg_pkg and mfsg_if.
module mfsg_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  mfsg_cfg_if.sink       cfg_i,
  output mfsg_pkg::cfg_t cfg_o
);
  import mfsg_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  // Take a write transfer into the addressed register, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size       <= RST_0P01;
      cfg_q.global_bias     <= '0;
      cfg_q.factor_count    <= 5'(MAX_FACTORS);
      cfg_q.user_factor_reg <= RST_0P01;
      cfg_q.item_factor_reg <= RST_0P01;
      cfg_q.user_bias_reg   <= RST_0P01;
      cfg_q.item_bias_reg   <= RST_0P01;
      cfg_q.user_base       <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.addr)
        REG_STEP_SIZE:       cfg_q.step_size       <= cfg_i.data.wdata;
        REG_GLOBAL_BIAS:     cfg_q.global_bias     <= cfg_i.data.wdata;
        REG_FACTOR_COUNT:    cfg_q.factor_count    <= cfg_i.data.wdata[4:0];
        REG_USER_FACTOR_REG: cfg_q.user_factor_reg <= cfg_i.data.wdata;
        REG_ITEM_FACTOR_REG: cfg_q.item_factor_reg <= cfg_i.data.wdata;
        REG_USER_BIAS_REG:   cfg_q.user_bias_reg   <= cfg_i.data.wdata;
        REG_ITEM_BIAS_REG:   cfg_q.item_bias_reg   <= cfg_i.data.wdata;
        REG_USER_BASE:       cfg_q.user_base       <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/mfsg_mac.sv
// Shared 32x32 signed multiplier with a product register, followed by the
// Q8.24 floor shift and saturation. Depends on mfsg_pkg.
module mfsg_mac (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [mfsg_pkg::DATA_W-1:0]  a_i,
  input  logic signed [mfsg_pkg::DATA_W-1:0]  b_i,
  output mfsg_pkg::sres_t                     res_o
);
  import mfsg_pkg::*;

  logic signed [2*DATA_W-1:0] prod_q;

  // Register the full product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign res_o = sat_shift(prod_q);

endmodule

### test/mfsg_checker.sv
// Checker for the gradient engine: watches the configuration, input and result
// channels, predicts every result and compares. Depends on mfsg_pkg and mfsg_if.
module mfsg_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mfsg_cfg_if  cfg_m,
  mfsg_in_if   in_m,
  mfsg_out_if  out_m,
  output int   fail_count_o,
  output int   open_results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mfsg_pkg::*;

  // Shadow configuration
  logic signed [31:0] lr_q, gbias_q, ufreg_q, ifreg_q, ubreg_q, ibreg_q;
  logic [4:0]         fcount_q;
  logic [31:0]        base_q;

  // Shadow tables and bias gradient sums
  logic signed [31:0] ubias_tab [USER_SLOTS];
  logic signed [31:0] uwt_tab   [USER_SLOTS][MAX_FACTORS];
  logic signed [31:0] ibias_tab [ITEM_SLOTS];
  logic signed [31:0] iwt_tab   [ITEM_SLOTS][MAX_FACTORS];
  logic signed [31:0] ugrad_sum [USER_SLOTS];
  logic signed [31:0] igrad_sum [ITEM_SLOTS];

  // Newest prediction at the front, oldest taken from the back
  out_t delta_queue [$];
  bit   ovf_seen;
  int   fails;

  assign fail_count_o   = fails;
  assign open_results_o = delta_queue.size();

  // Clamp to 32 bits and note any overflow of the current rating
  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      ovf_seen = 1'b1;
      return SAT_MAX;
    end
    if (v < -64'sd2147483648) begin
      ovf_seen = 1'b1;
      return SAT_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  // Full product, floor shift back to Q8.24
  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> FRAC_BITS);
  endfunction

  // Work out the delta pairs of one rating and queue them
  task automatic predict_rating(in_t it);
    int fc;
    logic signed [31:0] ub, ib, pred, err, uw, iw;
    logic signed [31:0] ud [MAX_FACTORS];
    logic signed [31:0] idl [MAX_FACTORS];
    out_t r;
    fc = (fcount_q == 0) ? 1 : (fcount_q > MAX_FACTORS) ? MAX_FACTORS : fcount_q;
    ovf_seen = 1'b0;
    ub = ubias_tab[it.user_slot];
    ib = ibias_tab[it.item_key];
    pred = qadd(qadd(gbias_q, ub), ib);
    for (int k = 0; k < fc; k++) begin
      pred = qadd(pred, qmul(uwt_tab[it.user_slot][k], iwt_tab[it.item_key][k]));
    end
    err = qsub(it.value, pred);
    ugrad_sum[it.user_slot] = qadd(ugrad_sum[it.user_slot],
                                   qmul(lr_q, qsub(err, qmul(ubreg_q, ub))));
    igrad_sum[it.item_key] = qadd(igrad_sum[it.item_key],
                                  qmul(lr_q, qsub(err, qmul(ibreg_q, ib))));
    for (int k = 0; k < fc; k++) begin
      uw = uwt_tab[it.user_slot][k];
      iw = iwt_tab[it.item_key][k];
      ud[k]  = qmul(lr_q, qsub(qmul(err, iw), qmul(ufreg_q, uw)));
      idl[k] = qmul(lr_q, qsub(qmul(err, uw), qmul(ifreg_q, iw)));
    end
    for (int k = 0; k < fc; k++) begin
      r.global_user   = base_q + 32'(it.user_slot);
      r.item_out      = it.item_key;
      r.factor_out    = 4'(k);
      r.prediction    = pred;
      r.user_delta    = ud[k];
      r.item_delta    = idl[k];
      r.user_bias_sum = ugrad_sum[it.user_slot];
      r.item_bias_sum = igrad_sum[it.item_key];
      r.saturated     = ovf_seen;
      r.last          = (k == fc - 1);
      delta_queue.push_front(r);
    end
  endtask

  function automatic string diff_fields(out_t e, out_t g);
    string s;
    s = "";
    if (e.global_user   !== g.global_user)   s = {s, " global_user"};
    if (e.item_out      !== g.item_out)      s = {s, " item_out"};
    if (e.factor_out    !== g.factor_out)    s = {s, " factor_out"};
    if (e.prediction    !== g.prediction)    s = {s, " prediction"};
    if (e.user_delta    !== g.user_delta)    s = {s, " user_delta"};
    if (e.item_delta    !== g.item_delta)    s = {s, " item_delta"};
    if (e.user_bias_sum !== g.user_bias_sum) s = {s, " user_bias_sum"};
    if (e.item_bias_sum !== g.item_bias_sum) s = {s, " item_bias_sum"};
    if (e.saturated     !== g.saturated)     s = {s, " saturated"};
    if (e.last          !== g.last)          s = {s, " last"};
    return s;
  endfunction

  // Follow every transfer on the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_t  exp_r;
    string bad;
    if (!rst_ni) begin
      lr_q <= RST_0P01; gbias_q <= '0; fcount_q <= 5'd16;
      ufreg_q <= RST_0P01; ifreg_q <= RST_0P01;
      ubreg_q <= RST_0P01; ibreg_q <= RST_0P01; base_q <= '0;
      foreach (ugrad_sum[i]) ugrad_sum[i] = '0;
      foreach (igrad_sum[i]) igrad_sum[i] = '0;
      delta_queue.delete();
      fails <= 0;
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.data.addr)
          REG_STEP_SIZE:       lr_q     <= cfg_m.data.wdata;
          REG_GLOBAL_BIAS:     gbias_q  <= cfg_m.data.wdata;
          REG_FACTOR_COUNT:    fcount_q <= cfg_m.data.wdata[4:0];
          REG_USER_FACTOR_REG: ufreg_q  <= cfg_m.data.wdata;
          REG_ITEM_FACTOR_REG: ifreg_q  <= cfg_m.data.wdata;
          REG_USER_BIAS_REG:   ubreg_q  <= cfg_m.data.wdata;
          REG_ITEM_BIAS_REG:   ibreg_q  <= cfg_m.data.wdata;
          REG_USER_BASE:       base_q   <= cfg_m.data.wdata;
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready) begin
        case (in_m.data.mode)
          MODE_WR_USER: if (in_m.data.word_index <= MAX_FACTORS) begin
            if (in_m.data.word_index == 0) ubias_tab[in_m.data.user_slot] = in_m.data.value;
            else uwt_tab[in_m.data.user_slot][in_m.data.word_index - 1] = in_m.data.value;
          end
          MODE_WR_ITEM: if (in_m.data.word_index <= MAX_FACTORS) begin
            if (in_m.data.word_index == 0) ibias_tab[in_m.data.item_key] = in_m.data.value;
            else iwt_tab[in_m.data.item_key][in_m.data.word_index - 1] = in_m.data.value;
          end
          MODE_RATING: predict_rating(in_m.data);
          default: begin
            foreach (ugrad_sum[i]) ugrad_sum[i] = '0;
            foreach (igrad_sum[i]) igrad_sum[i] = '0;
          end
        endcase
      end
      if (out_m.valid && out_m.ready) begin
        if (delta_queue.size() == 0) begin
          if (fails < 10) $display("ERROR: unexpected result %p", out_m.data);
          fails <= fails + 1;
        end else begin
          exp_r = delta_queue.pop_back();
          bad = diff_fields(exp_r, out_m.data);
          if (bad != "") begin
            if (fails < 10) begin
              $display("ERROR: mismatch in%s", bad);
              $display("  expected %p", exp_r);
              $display("  actual   %p", out_m.data);
            end
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

### test/testbench.sv
// Top of the gradient engine testbench: clock, reset, stimulus and verdict.
// Depends on mfsg_pkg, mfsg_if, mfsg_checker and the engine itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mfsg_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int CLEAR_SWEEP = 1100;

  logic clk_i, rst_ni;
  mfsg_cfg_if cfg_ch ();
  mfsg_in_if  in_ch ();
  mfsg_out_if out_ch ();
  int fail_count, open_results, cycles, ratings_sent, items_sent, cfg_sets;
  int send_idle, recv_idle;

  bit user_ready [USER_SLOTS];
  bit item_ready [ITEM_SLOTS];
  int user_pool [$];
  int item_pool [$];

  mf_sgd_gradient_engine u_dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .cfg_i(cfg_ch), .in_i(in_ch), .out_o(out_ch)
  );

  mfsg_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_m(cfg_ch), .in_m(in_ch), .out_m(out_ch),
    .fail_count_o(fail_count), .open_results_o(open_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Mostly values within a few units, sometimes anything
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(9))
      0: return $urandom();
      1: return ($urandom_range(1)) ? SAT_MAX : SAT_MIN;
      default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  // Hold one item until the engine takes it
  task automatic push_item(in_t it);
    bit took;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
    if (it.mode == MODE_RATING) ratings_sent++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    bit took;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{addr: idx, wdata: val};
    do begin
      @(negedge clk_i);
      took = cfg_ch.ready;
      @(posedge clk_i);
    end while (!took);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_word(logic [1:0] mode, int slot, int key, int word, logic signed [31:0] v);
    push_item('{mode: mode, user_slot: 8'(slot), item_key: 10'(key),
                word_index: 5'(word), value: v});
  endtask

  // Fill every word of a user or item before any rating reads it
  task automatic prime_user(int slot);
    if (!user_ready[slot]) begin
      for (int w = 0; w <= MAX_FACTORS; w++) load_word(MODE_WR_USER, slot, $urandom, w, rand_word());
      user_ready[slot] = 1;
      user_pool.push_front(slot);
    end
  endtask

  task automatic prime_item(int key);
    if (!item_ready[key]) begin
      for (int w = 0; w <= MAX_FACTORS; w++) load_word(MODE_WR_ITEM, $urandom, key, w, rand_word());
      item_ready[key] = 1;
      item_pool.push_front(key);
    end
  endtask

  task automatic rate(int slot, int key, logic signed [31:0] v);
    prime_user(slot);
    prime_item(key);
    load_word(MODE_RATING, slot, key, $urandom, v);
  endtask

  // Let the engine drain, including a clearing sweep, before a register write
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (open_results == 0);
    repeat (CLEAR_SWEEP) @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] lr, logic [31:0] gb, logic [4:0] fc,
                            logic [31:0] regv, logic [31:0] base);
    drain();
    write_reg(REG_STEP_SIZE, lr);
    write_reg(REG_GLOBAL_BIAS, gb);
    write_reg(REG_FACTOR_COUNT, {$urandom_range(1) ? 27'h7FF_FFFF : 27'h0, fc});
    write_reg(REG_USER_FACTOR_REG, regv);
    write_reg(REG_ITEM_FACTOR_REG, regv ^ 32'h0001_0000);
    write_reg(REG_USER_BIAS_REG, ~regv);
    write_reg(REG_ITEM_BIAS_REG, regv + 32'd7);
    write_reg(REG_USER_BASE, base);
    cfg_sets++;
  endtask

  // One stretch of random traffic, mostly ratings on known users and items
  task automatic random_stretch(int n);
    int slot, key, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      slot = (user_pool.size() > 0 && $urandom_range(19) != 0) ?
             user_pool[$urandom_range(user_pool.size() - 1)] : $urandom_range(USER_SLOTS - 1);
      key  = (item_pool.size() > 0 && $urandom_range(19) != 0) ?
             item_pool[$urandom_range(item_pool.size() - 1)] : $urandom_range(ITEM_SLOTS - 1);
      if (pick < 65) rate(slot, key, rand_word());
      else if (pick < 75) load_word(MODE_WR_USER, slot, $urandom, $urandom_range(31), rand_word());
      else if (pick < 85) load_word(MODE_WR_ITEM, $urandom, key, $urandom_range(31), rand_word());
      else if (pick < 87) load_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
      else begin
        // overwrite one word of a primed user then rate it at once
        if (user_ready[slot]) load_word(MODE_WR_USER, slot, 0, $urandom_range(MAX_FACTORS),
                                        rand_word());
        rate(slot, key, rand_word());
      end
      if (i == n / 2 && $urandom_range(1)) begin
        // hold off until every pending result is out
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        wait (open_results == 0);
        @(posedge clk_i);
      end
    end
  endtask

  initial begin
    cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_ni = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, corner slots and keys, extremes, ignored writes
    rate(0, 0, 32'sh0100_0000);
    rate(255, 1023, SAT_MAX);
    rate(255, 0, SAT_MIN);
    rate(0, 1023, 32'sh0);
    load_word(MODE_WR_USER, 3, 0, 17, SAT_MAX);
    load_word(MODE_WR_ITEM, 0, 5, 31, SAT_MIN);
    for (int w = 0; w <= MAX_FACTORS; w++) load_word(MODE_WR_USER, 128, 0, w, SAT_MAX);
    for (int w = 0; w <= MAX_FACTORS; w++) load_word(MODE_WR_ITEM, 0, 512, w, SAT_MIN);
    user_ready[128] = 1; user_pool.push_front(128);
    item_ready[512] = 1; item_pool.push_front(512);
    rate(128, 512, SAT_MAX);
    rate(128, 512, SAT_MIN);
    load_word(MODE_CLEAR, 0, 0, 0, 0);
    rate(0, 0, 32'sh0080_0000);
    set_config(SAT_MAX, SAT_MIN, 5'd0, SAT_MAX, 32'hFFFF_FFFF);
    rate(255, 1023, 32'sh7FFF_0000);
    rate(128, 512, 32'sh1);
    set_config(SAT_MIN, SAT_MAX, 5'd31, SAT_MIN, 32'hFFFF_FF80);
    rate(255, 1023, SAT_MIN);
    rate(0, 0, SAT_MAX);

    // Random traffic over three idle patterns and two settings each
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 16 : (ph == 1) ? 75 : 0;
      recv_idle = (ph == 0) ? 75 : (ph == 1) ? 16 : 0;
      set_config(32'd167772, $urandom, 5'd1, 32'd167772, $urandom);
      random_stretch(20);
      set_config($urandom_range(32'h0200_0000), rand_word(), 5'($urandom_range(2, 16)),
                 rand_word(), $urandom);
      random_stretch(20);
    end
    drain();
    write_reg(REG_FACTOR_COUNT, 32'd16);
    rate(255, 1023, 32'sh0100_0000);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (open_results == 0);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d items, %0d of them ratings, under %0d register settings",
             items_sent, ratings_sent, cfg_sets);
    $display("Idle patterns: sender-light, receiver-light and none; %0d mismatches",
             fail_count);
    if (fail_count == 0 && open_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
